// ----- rtl/segsum_pkg.sv -----
package segsum_pkg;

   localparam int LEAVES_DEF = 1024;
   localparam int SUM_W      = 48;
   localparam int VAL_W      = 32;
   localparam int POS_W      = 10;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_WRITE,
      ST_QRY_LEFT,
      ST_QRY_RIGHT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                    load;
      logic signed [SUM_W-1:0] sum;
   } res_type;

endpackage

// ----- rtl/segment_tree_range_sum.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | op, position, new_value, range_low, range_high
// rsp     | out       | rsp_valid/rsp_stall  | range_sum (one item per query)
//
// an update writes its leaf, then a read step and a write step per level up to the root, one
// adder and one node ram read port shared by all levels; a query runs left and right steps up
// the tree and a finish step (at once for an empty range) that waits for the output register.
// after reset a clearing pass writes zeros to all 2*LEAVES nodes, one per cycle,
// with req_stall high throughout.
// a finished sum waits in the output register; the next item is taken meanwhile,
// and a later query holds in its last step until that register is free.
module segment_tree_range_sum #(
   parameter int LEAVES = segsum_pkg::LEAVES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [segsum_pkg::POS_W-1:0]         req_position,
   input  logic signed [segsum_pkg::VAL_W-1:0]  req_new_value,
   input  logic [segsum_pkg::POS_W-1:0]         req_range_low,
   input  logic [segsum_pkg::POS_W-1:0]         req_range_high,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [segsum_pkg::SUM_W-1:0]  rsp_range_sum
);
   import segsum_pkg::*;

   localparam int NODES = 2 * LEAVES;
   localparam int IDX_W = $clog2(NODES);

   res_type res;
   logic out_free;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic signed [SUM_W-1:0] wr_data, rd_data;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   segsum_seq #(
      .LEAVES(LEAVES)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .out_free       (out_free),
      .res            (res),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   segsum_node_ram #(
      .DEPTH(NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      if (res.load) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = res.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

endmodule

// ----- rtl/segsum_node_ram.sv -----
module segsum_node_ram #(
   parameter int DEPTH = 2 * segsum_pkg::LEAVES_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(DEPTH)-1:0]             wr_addr,
   input  logic signed [segsum_pkg::SUM_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]             rd_addr,
   output logic signed [segsum_pkg::SUM_W-1:0]  rd_data
);
   import segsum_pkg::*;

   logic signed [SUM_W-1:0] mem [DEPTH];
   logic signed [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/segsum_seq.sv -----
module segsum_seq #(
   parameter int LEAVES = segsum_pkg::LEAVES_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic                                          req_op,
   input  logic [segsum_pkg::POS_W-1:0]                  req_position,
   input  logic signed [segsum_pkg::VAL_W-1:0]           req_new_value,
   input  logic [segsum_pkg::POS_W-1:0]                  req_range_low,
   input  logic [segsum_pkg::POS_W-1:0]                  req_range_high,
   input  logic                                          out_free,
   output segsum_pkg::res_type                           res,
   output logic                                          wr_en,
   output logic [$clog2(2*LEAVES)-1:0]                   wr_addr,
   output logic signed [segsum_pkg::SUM_W-1:0]           wr_data,
   output logic [$clog2(2*LEAVES)-1:0]                   rd_addr,
   input  logic signed [segsum_pkg::SUM_W-1:0]           rd_data
);
   import segsum_pkg::*;

   localparam int NODES = 2 * LEAVES;
   localparam int IDX_W = $clog2(NODES);
   localparam int EXT_W = IDX_W + 1;
   localparam logic [31:0] LEAVES_32 = 32'(LEAVES);
   localparam logic [IDX_W-1:0] LEAVES_IDX = IDX_W'(LEAVES);
   localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);
   localparam logic [IDX_W-1:0] ROOT = IDX_W'(1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] l_ff, l_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic pend_l_ff, pend_l_in;
   logic pend_r_ff, pend_r_in;

   logic signed [SUM_W-1:0] add_a, add_b, add_y;
   logic signed [SUM_W-1:0] new_ext;
   logic [31:0] pos_32, lo_32, hi_32, hi_clamp;
   logic [IDX_W-1:0] parent;
   logic [EXT_W-1:0] l_step, r_step;
   logic query_empty;

   // shared adder
   assign add_y = add_a + add_b;

   assign new_ext  = {{(SUM_W-VAL_W){req_new_value[VAL_W-1]}}, req_new_value};
   assign pos_32   = 32'(req_position);
   assign lo_32    = 32'(req_range_low);
   assign hi_32    = 32'(req_range_high);
   assign hi_clamp = (hi_32 >= LEAVES_32) ? (LEAVES_32 - 32'd1) : hi_32;
   assign query_empty = (lo_32 >= LEAVES_32) || (hi_clamp < lo_32);
   assign parent   = k_ff >> 1;
   assign l_step   = (EXT_W'(l_ff) + EXT_W'(l_ff[0])) >> 1;
   assign r_step   = (EXT_W'(r_ff) - EXT_W'(!r_ff[0])) >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      k_ff      <= k_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      acc_ff    <= acc_in;
      pend_l_ff <= pend_l_in;
      pend_r_ff <= pend_r_in;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      pend_l_in = pend_l_ff;
      pend_r_in = pend_r_ff;
      add_a     = acc_ff;
      add_b     = '0;
      wr_en     = 1'b0;
      wr_addr   = k_ff;
      wr_data   = add_y;
      rd_addr   = k_ff ^ ROOT;
      req_stall = (state_ff != ST_IDLE);
      res.load  = 1'b0;
      res.sum   = acc_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_UPDATE) begin
                  if (pos_32 < LEAVES_32) begin
                     wr_en    = 1'b1;
                     wr_addr  = IDX_W'(req_position) + LEAVES_IDX;
                     wr_data  = new_ext;
                     k_in     = IDX_W'(req_position) + LEAVES_IDX;
                     acc_in   = new_ext;
                     state_in = ST_UPD_READ;
                  end
               end else begin
                  acc_in    = '0;
                  pend_l_in = 1'b0;
                  pend_r_in = 1'b0;
                  l_in      = IDX_W'(req_range_low) + LEAVES_IDX;
                  r_in      = IDX_W'(hi_clamp) + LEAVES_IDX;
                  state_in  = query_empty ? ST_FINISH : ST_QRY_LEFT;
               end
            end
         end
         ST_UPD_READ: begin
            rd_addr  = k_ff ^ ROOT;
            state_in = ST_UPD_WRITE;
         end
         ST_UPD_WRITE: begin
            // running node value plus sibling
            add_a   = acc_ff;
            add_b   = rd_data;
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = add_y;
            acc_in  = add_y;
            k_in    = parent;
            state_in = (parent > ROOT) ? ST_UPD_READ : ST_IDLE;
         end
         ST_QRY_LEFT: begin
            add_b     = pend_r_ff ? rd_data : '0;
            acc_in    = add_y;
            pend_r_in = 1'b0;
            rd_addr   = l_ff;
            if ((l_ff <= r_ff) && (l_ff != '0)) begin
               pend_l_in = l_ff[0];
               state_in  = ST_QRY_RIGHT;
            end else begin
               state_in  = ST_FINISH;
            end
         end
         ST_QRY_RIGHT: begin
            add_b     = pend_l_ff ? rd_data : '0;
            acc_in    = add_y;
            pend_l_in = 1'b0;
            pend_r_in = !r_ff[0];
            rd_addr   = r_ff;
            l_in      = l_step[IDX_W-1:0];
            r_in      = r_step[IDX_W-1:0];
            state_in  = ST_QRY_LEFT;
         end
         ST_FINISH: begin
            if (out_free) begin
               res.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/segsum_checker.sv -----
module segsum_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_op,
   input logic [segsum_pkg::POS_W-1:0]         req_range_low,
   input logic [segsum_pkg::POS_W-1:0]         req_range_high,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [segsum_pkg::SUM_W-1:0]  rsp_range_sum
);
   import segsum_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_range_sum))
      else $error("rsp item changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during clearing pass");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_QUERY |=> req_stall)
      else $error("query did not occupy the block");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_QUERY && !rsp_valid
      && req_range_high < req_range_low
      |-> ##2 (rsp_valid && rsp_range_sum == '0))
      else $error("empty range did not give zero");

endmodule

bind segment_tree_range_sum segsum_checker u_segsum_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_op         (req_op),
   .req_range_low  (req_range_low),
   .req_range_high (req_range_high),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_range_sum  (rsp_range_sum)
);
